// ===== sv/ternary_dot_product_prelu_core_defines.svh =====
// Assertion macros shared by the ternary dot product core.
// In synthesis builds the macros expand to nothing.
`ifndef TERNARY_DOT_PRODUCT_PRELU_CORE_DEFINES_SVH
`define TERNARY_DOT_PRODUCT_PRELU_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define TTDP_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Checks that a condition implies another one in the next cycle.
`define TTDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TTDP_ASSERT_NOW(lbl, clk, rst_n, expr, msg)
`define TTDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/ttdp_pkg.sv =====
`timescale 1ns / 1ps

package ttdp_pkg;

	// Lane organization: the word carries LANES ternary lanes per operand.
	localparam int LANES       = 64;
	localparam int PLANE_W     = 64;
	localparam int GROUP_LANES = 8;
	localparam int GROUPS      = LANES / GROUP_LANES;

	// A group of lanes yields a value in [-GROUP_LANES, GROUP_LANES].
	localparam int GRP_W   = $clog2(GROUP_LANES) + 2;
	// A whole word yields a value in [-LANES, LANES].
	localparam int CHUNK_W = $clog2(LANES) + 2;

	// Running sum and result widths.
	localparam int MAX_TOTAL = 65536;
	localparam int SUM_W     = 18;
	localparam int SUMX_W    = SUM_W + 1;
	localparam int SLOPE_W   = 16;
	localparam int FRAC_W    = 12;
	localparam int ACT_W     = 33;
	localparam int PROD_W    = SUM_W + SLOPE_W;

	// Stream word widths.
	localparam int IN_DATA_W  = 4 * PLANE_W;
	localparam int OUT_BITS   = SUM_W + ACT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic signed [GRP_W-1:0]   grp_sum_t;
	typedef logic signed [CHUNK_W-1:0] chunk_sum_t;
	typedef logic signed [SUM_W-1:0]   dot_sum_t;
	typedef logic signed [SLOPE_W-1:0] slope_t;
	typedef logic signed [ACT_W-1:0]   act_t;

	// Hand-off of a word from the lane stage into the accumulator.
	typedef struct packed {
		logic load;
		logic last;
	} stage_ctl_t;

endpackage

// ===== sv/ttdp_lane_group.sv =====
`timescale 1ns / 1ps

// One lane group: forms the ternary products of GROUP_LANES lanes and
// registers their sum.
module ttdp_lane_group (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic [ttdp_pkg::GROUP_LANES-1:0]      left_sign,
	input  logic [ttdp_pkg::GROUP_LANES-1:0]      left_nonzero,
	input  logic [ttdp_pkg::GROUP_LANES-1:0]      right_sign,
	input  logic [ttdp_pkg::GROUP_LANES-1:0]      right_nonzero,
	output ttdp_pkg::grp_sum_t                    group_sum_s1
);

	ttdp_pkg::grp_sum_t acc;

	// Each lane adds +1 or -1 when both operands are nonzero.
	always_comb begin
		acc = '0;
		for (int i = 0; i < ttdp_pkg::GROUP_LANES; i++) begin
			if (left_nonzero[i] && right_nonzero[i]) begin
				if (left_sign[i] ^ right_sign[i]) begin
					acc = acc - 1'b1;
				end else begin
					acc = acc + 1'b1;
				end
			end
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk) begin
		if (load) begin
			group_sum_s1 <= acc;
		end
	end

endmodule

// ===== sv/ttdp_merge.sv =====
`timescale 1ns / 1ps
`include "ternary_dot_product_prelu_core_defines.svh"

// Merges the lane group sums into the word's sum and keeps the saturating
// running sum. The sum of a last word is handed on in stage 2.
module ttdp_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttdp_pkg::stage_ctl_t  ctl,
	input  ttdp_pkg::grp_sum_t    group_sum_s1 [ttdp_pkg::GROUPS],
	output ttdp_pkg::dot_sum_t    dot_sum_s2
);

	localparam logic signed [ttdp_pkg::SUMX_W-1:0] SAT_HI = ttdp_pkg::SUMX_W'(ttdp_pkg::MAX_TOTAL);
	localparam logic signed [ttdp_pkg::SUMX_W-1:0] SAT_LO = -SAT_HI;

	ttdp_pkg::chunk_sum_t                chunk;
	logic signed [ttdp_pkg::SUMX_W-1:0]  total;
	ttdp_pkg::dot_sum_t                  sat_sum;
	ttdp_pkg::dot_sum_t                  running_sum_q;

	// Adder tree over the group sums.
	always_comb begin
		chunk = '0;
		for (int g = 0; g < ttdp_pkg::GROUPS; g++) begin
			chunk = chunk + ttdp_pkg::CHUNK_W'(group_sum_s1[g]);
		end
	end

	// Add the word to the running sum and clamp to the bounds.
	always_comb begin
		total = ttdp_pkg::SUMX_W'(running_sum_q) + ttdp_pkg::SUMX_W'(chunk);
		if (total > SAT_HI) begin
			sat_sum = ttdp_pkg::SUM_W'(SAT_HI);
		end else if (total < SAT_LO) begin
			sat_sum = ttdp_pkg::SUM_W'(SAT_LO);
		end else begin
			sat_sum = ttdp_pkg::SUM_W'(total);
		end
	end

	// Running sum clears after a last word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (ctl.load) begin
			running_sum_q <= ctl.last ? '0 : sat_sum;
		end
	end

	// Stage 2 register holds the finished sum.
	always_ff @(posedge clk) begin
		if (ctl.load && ctl.last) begin
			dot_sum_s2 <= sat_sum;
		end
	end

	`TTDP_ASSERT_NOW(a_sum_in_range, clk, arst_n,
		(ttdp_pkg::SUMX_W'(running_sum_q) <= SAT_HI) &&
		(ttdp_pkg::SUMX_W'(running_sum_q) >= SAT_LO),
		"running sum left the saturation bounds")
	`TTDP_ASSERT_NEXT(a_sum_clears, clk, arst_n, ctl.load && ctl.last, running_sum_q == '0,
		"running sum not cleared after a last word")

endmodule

// ===== sv/ttdp_prelu.sv =====
`timescale 1ns / 1ps
`include "ternary_dot_product_prelu_core_defines.svh"

// Output stage: applies the PReLU to a finished sum and holds the result
// word until it is taken.
module ttdp_prelu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ttdp_pkg::dot_sum_t  dot_sum_s2,
	input  ttdp_pkg::slope_t    leak_slope,
	output logic                out_valid,
	input  logic                out_ready,
	output ttdp_pkg::dot_sum_t  dot_sum,
	output ttdp_pkg::act_t      activation
);

	logic signed [ttdp_pkg::PROD_W-1:0] prod;
	ttdp_pkg::act_t                     act_next;
	logic                               load;

	assign in_ready = !out_valid || out_ready;
	assign load     = in_valid && in_ready;

	// Positive sums scale by one in Q3.12, the rest by the slope.
	always_comb begin
		prod = ttdp_pkg::PROD_W'(dot_sum_s2) * ttdp_pkg::PROD_W'(leak_slope);
		if (dot_sum_s2 > 0) begin
			act_next = ttdp_pkg::ACT_W'(dot_sum_s2) <<< ttdp_pkg::FRAC_W;
		end else begin
			act_next = ttdp_pkg::ACT_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dot_sum    <= dot_sum_s2;
			activation <= act_next;
		end
	end

	`TTDP_ASSERT_NOW(a_pos_scale, clk, arst_n,
		!(out_valid && (dot_sum > 0)) ||
		(activation == (ttdp_pkg::ACT_W'(dot_sum) <<< ttdp_pkg::FRAC_W)),
		"positive sum not scaled by one")
	`TTDP_ASSERT_NOW(a_zero_act, clk, arst_n,
		!(out_valid && (dot_sum == '0)) || (activation == '0),
		"zero sum gave a nonzero activation")

endmodule

// ===== sv/ternary_dot_product_prelu_core.sv =====
`timescale 1ns / 1ps
`include "ternary_dot_product_prelu_core_defines.svh"

// Channel      Direction  Word contents
// s_axis       in         256-bit planes of 64 ternary lanes; tlast ends a dot product
// m_axis       out        signed sum and PReLU activation, one word per dot product
// leak_slope   in         write enable and signed Q3.12 slope for negative sums
//
// One input word is taken every cycle unless a last word is held in stage 1; eight lane groups and one adder tree
// handle all 64 lanes of a word in its single lane stage.
// A result passes the stage 1 group sums, the stage 2 sum register and the output register on its way to m_axis.
// Reset clears the pipeline, the running sum and the slope.
// While m_axis is stalled, words that are not last still go into the running
// sum; s_axis stalls only when a second finished sum waits behind the result.
module ternary_dot_product_prelu_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               leak_slope_we,
	input  logic [ttdp_pkg::SLOPE_W-1:0]       leak_slope_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// left_sign, left_nonzero, right_sign, right_nonzero
	input  logic [ttdp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// dot_sum, activation, zero fill
	output logic [ttdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	localparam int PW = ttdp_pkg::PLANE_W;
	localparam int GL = ttdp_pkg::GROUP_LANES;

	ttdp_pkg::slope_t      leak_slope_q;
	logic                  valid_s1;
	logic                  last_s1;
	logic                  valid_s2;
	logic                  in_accept;
	logic                  adv_s1;
	logic                  out_ready;
	logic                  load_s3;
	ttdp_pkg::stage_ctl_t  merge_ctl;
	ttdp_pkg::grp_sum_t    group_sum_s1 [ttdp_pkg::GROUPS];
	ttdp_pkg::dot_sum_t    dot_sum_s2;
	ttdp_pkg::dot_sum_t    dot_sum;
	ttdp_pkg::act_t        activation;

	// Slope register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_slope_q <= '0;
		end else if (leak_slope_we) begin
			leak_slope_q <= leak_slope_wdata;
		end
	end

	// A word leaves stage 1 unless it is last and stage 2 cannot take it.
	assign load_s3       = valid_s2 && out_ready;
	assign adv_s1        = valid_s1 && (!last_s1 || !valid_s2 || load_s3);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign merge_ctl = '{load: adv_s1, last: last_s1};

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1 && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (load_s3) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			last_s1 <= s_axis_tlast;
		end
	end

	// Lane groups work side by side on the word.
	for (genvar g = 0; g < ttdp_pkg::GROUPS; g++) begin : g_lane
		ttdp_lane_group u_group (
			.clk           (clk),
			.load          (in_accept),
			.left_sign     (s_axis_tdata[0 * PW + g * GL +: GL]),
			.left_nonzero  (s_axis_tdata[1 * PW + g * GL +: GL]),
			.right_sign    (s_axis_tdata[2 * PW + g * GL +: GL]),
			.right_nonzero (s_axis_tdata[3 * PW + g * GL +: GL]),
			.group_sum_s1  (group_sum_s1[g])
		);
	end

	ttdp_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (merge_ctl),
		.group_sum_s1 (group_sum_s1),
		.dot_sum_s2   (dot_sum_s2)
	);

	ttdp_prelu u_prelu (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s2),
		.in_ready   (out_ready),
		.dot_sum_s2 (dot_sum_s2),
		.leak_slope (leak_slope_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.dot_sum    (dot_sum),
		.activation (activation)
	);

	// Pack the result word, sum in the low bits.
	assign m_axis_tdata = {
		{(ttdp_pkg::OUT_DATA_W - ttdp_pkg::OUT_BITS){1'b0}}, activation, dot_sum
	};

	`TTDP_ASSERT_NOW(a_ready_when_out_empty, clk, arst_n, m_axis_tvalid || s_axis_tready,
		"input stalled with an empty output")

endmodule
